[hw/rtl/batch_norm_inference_unit_macros.svh]
// assertion helpers shared by the batch norm rtl
`ifndef BATCH_NORM_INFERENCE_UNIT_MACROS_SVH
`define BATCH_NORM_INFERENCE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BNI_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define BNI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bnorm_pkg.sv]
`timescale 1ns / 1ps

package bnorm_pkg;

    // channel store
    localparam int CHANNELS = 64;
    localparam int CHAN_W   = 6;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // data widths
    localparam int SAMPLE_BITS = 16;
    localparam int PARAM_W     = 16;
    localparam int FACT_W      = 32;

    // inverse square root unit
    localparam int W_W     = 25;              // variance * 256 + epsilon
    localparam int QUO_W   = 49;              // floor(2^48 / w)
    localparam int RAD_W   = 50;              // radicand width
    localparam int RS_W    = 25;              // root width
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] DIV_TOP  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] SQRT_TOP = CNT_W'(RS_W - 1);

    // shared multiplier and accumulator
    localparam int DIFF_W  = ((SAMPLE_BITS > PARAM_W) ? SAMPLE_BITS : PARAM_W) + 1;
    localparam int MUL_A_W = FACT_W + 1;
    localparam int MUL_B_W = DIFF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam logic [ACC_W-1:0] RND_HALF_F = ACC_W'(64'd1 << 7);
    localparam logic [ACC_W-1:0] RND_HALF_S = ACC_W'(64'd1 << 15);
    localparam logic [ACC_W-1:0] F_MAX_MAG  = ACC_W'(64'h7FFF_FFFF);
    localparam logic [ACC_W-1:0] F_MIN_MAG  = ACC_W'(64'h8000_0000);
    localparam logic [ACC_W-1:0] Y_MAX_MAG  = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [ACC_W-1:0] Y_MIN_MAG  = ACC_W'(64'd1 << (SAMPLE_BITS - 1));

    // item function codes
    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    // configuration registers
    localparam int PADDR_W   = 3;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_EPSILON = 1'b0;
    localparam logic [15:0] EPS_RESET = 16'd1;

    typedef struct packed {
        logic [FACT_W-1:0]  factor;
        logic [PARAM_W-1:0] mean;
        logic [PARAM_W-1:0] bias;
    } chan_entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } isqrt_status_t;

endpackage

[hw/rtl/batch_norm_inference_unit.sv]
`timescale 1ns / 1ps
`include "batch_norm_inference_unit_macros.svh"

// per-channel batch normalization for inference, signed q8.8
// input channel s_*: valid/ready; s_func selects a parameter load or a sample
// output channel m_*: valid/ready; one transfer per sample item, none per load
// config: apb-style port, epsilon at byte address 0, pready tied high
// a load runs a 49-step restoring divide and a 25-step digit square root on one
// shared subtractor, then a multiply, round and table write before ready returns;
// the divide is skipped when variance and epsilon are both zero
// a sample reads the channel table, forms factor * (sample - mean) on the shared
// multiplier, adds bias, rounds and saturates into the output register;
// ready returns with the result, so a new sample is taken only once the last
// one's result is registered
// s_ready is high only while the sequencer is idle; one item is worked at a time
// the result sits in an output register; a stalled receiver holds the block in
// its final step until that register frees, so nothing is dropped or overwritten
// reset (aresetn low, synchronous) returns the sequencer to idle, clears m_valid
// and sets epsilon to 1; the channel table is not cleared and a sample must only
// name a channel that was loaded since reset
module batch_norm_inference_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // config port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bnorm_pkg::PADDR_W-1:0]         paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    // input items
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_func,
    input  logic [bnorm_pkg::CHAN_W-1:0]          s_channel,
    input  logic signed [bnorm_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic signed [bnorm_pkg::PARAM_W-1:0]  s_scale,
    input  logic signed [bnorm_pkg::PARAM_W-1:0]  s_bias,
    input  logic signed [bnorm_pkg::PARAM_W-1:0]  s_mean,
    input  logic [bnorm_pkg::PARAM_W-1:0]         s_variance,
    // result items
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bnorm_pkg::SAMPLE_BITS-1:0] m_result_value,
    output logic [bnorm_pkg::CHAN_W-1:0]          m_out_channel,
    output logic                                  m_saturated
);
    import bnorm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ISQ,
        ST_SREAD,
        ST_MUL,
        ST_ACC,
        ST_MAG,
        ST_RND,
        ST_WRITE,
        ST_OUT
    } bn_state_t;

    // ---------------- configuration ----------------
    logic [15:0]          eps_reg;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_EPSILON)) begin
            eps_reg <= pwdata[15:0];
        end
    end

    always_comb begin
        case (reg_idx)
            REG_EPSILON: prdata = {16'h0000, eps_reg};
            default:     prdata = 32'h0000_0000;
        endcase
    end

    // ---------------- sequencer registers ----------------
    bn_state_t                  state_reg;
    logic                       load_reg;      // item in flight is a load
    logic                       in_range_reg;
    logic [CHAN_W-1:0]          chan_reg;
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [PARAM_W-1:0]         scale_reg;
    logic [PARAM_W-1:0]         bias_in_reg;
    logic [PARAM_W-1:0]         mean_in_reg;
    logic [FACT_W-1:0]          f_reg;
    logic signed [DIFF_W-1:0]   d_reg;
    logic [PARAM_W-1:0]         bias_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       neg_reg;
    logic [ACC_W-1:0]           mag_reg;
    logic [ACC_W-1:0]           rnd_reg;
    logic                       m_valid_reg;
    logic [SAMPLE_BITS-1:0]     m_value_reg;
    logic [CHAN_W-1:0]          m_chan_reg;
    logic                       m_sat_reg;

    // ---------------- combinational helpers ----------------
    logic                       accept;
    logic                       chan_ok;
    logic [W_W-1:0]             w_val;
    logic                       isq_start;
    isqrt_status_t              isq_status;
    logic [RS_W-1:0]            isq_root;

    chan_entry_t                tbl_rd;
    chan_entry_t                tbl_wr;
    logic                       tbl_wr_en;
    logic                       tbl_rd_en;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   mul_p;
    logic signed [ACC_W-1:0]    bias_term;
    logic [ACC_W-1:0]           rnd_sum;
    logic [FACT_W-1:0]          fac_sat;
    logic [SAMPLE_BITS-1:0]     y_sat;
    logic                       y_clip;
    logic [FACT_W-1:0]          rd_factor;
    logic [PARAM_W-1:0]         rd_mean;
    logic [PARAM_W-1:0]         rd_bias;
    logic signed [DIFF_W-1:0]   diff_val;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign chan_ok   = (32'(s_channel) < 32'(CHANNELS));
    assign w_val     = W_W'({s_variance, 8'h00}) + W_W'(eps_reg);
    assign isq_start = accept && (s_func == FUNC_LOAD) && chan_ok;
    assign tbl_rd_en = accept && (s_func == FUNC_SAMPLE);
    assign tbl_wr_en = (state_reg == ST_WRITE);

    always_comb begin
        tbl_wr.factor = fac_sat;
        tbl_wr.mean   = mean_in_reg;
        tbl_wr.bias   = bias_in_reg;
    end

    // out-of-range channel reads as zero parameters
    assign rd_factor = in_range_reg ? tbl_rd.factor : '0;
    assign rd_mean   = in_range_reg ? tbl_rd.mean   : '0;
    assign rd_bias   = in_range_reg ? tbl_rd.bias   : '0;
    assign diff_val  = $signed({{(DIFF_W - SAMPLE_BITS){sample_reg[SAMPLE_BITS-1]}}, sample_reg})
                     - $signed({{(DIFF_W - PARAM_W){rd_mean[PARAM_W-1]}}, rd_mean});

    // shared multiplier: scale * root on loads, factor * (x - mean) on samples
    always_comb begin
        if (load_reg) begin
            mul_a = $signed({{(MUL_A_W - RS_W){1'b0}}, isq_root});
            mul_b = $signed({{(MUL_B_W - PARAM_W){scale_reg[PARAM_W-1]}}, scale_reg});
        end else begin
            mul_a = $signed({f_reg[FACT_W-1], f_reg});
            mul_b = d_reg;
        end
        mul_p = mul_a * mul_b;
    end

    // bias lines up with the q.24 product
    assign bias_term = load_reg ? '0
                     : $signed({{(ACC_W - PARAM_W - 16){bias_reg[PARAM_W-1]}}, bias_reg, 16'h0000});

    // round half away from zero on the magnitude
    assign rnd_sum = mag_reg + (load_reg ? RND_HALF_F : RND_HALF_S);

    always_comb begin
        if (!neg_reg && (rnd_reg > F_MAX_MAG)) begin
            fac_sat = {1'b0, {(FACT_W - 1){1'b1}}};
        end else if (neg_reg && (rnd_reg > F_MIN_MAG)) begin
            fac_sat = {1'b1, {(FACT_W - 1){1'b0}}};
        end else begin
            fac_sat = neg_reg ? (FACT_W'(0) - rnd_reg[FACT_W-1:0]) : rnd_reg[FACT_W-1:0];
        end
    end

    always_comb begin
        if (!neg_reg && (rnd_reg > Y_MAX_MAG)) begin
            y_sat  = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
            y_clip = 1'b1;
        end else if (neg_reg && (rnd_reg > Y_MIN_MAG)) begin
            y_sat  = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
            y_clip = 1'b1;
        end else begin
            y_sat  = neg_reg ? (SAMPLE_BITS'(0) - rnd_reg[SAMPLE_BITS-1:0])
                             : rnd_reg[SAMPLE_BITS-1:0];
            y_clip = 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            load_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // output register drains on a transfer unless a new result refills it
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        chan_reg     <= s_channel;
                        sample_reg   <= s_sample;
                        scale_reg    <= s_scale;
                        bias_in_reg  <= s_bias;
                        mean_in_reg  <= s_mean;
                        in_range_reg <= chan_ok;
                        load_reg     <= (s_func == FUNC_LOAD);
                        if (s_func == FUNC_SAMPLE) begin
                            state_reg <= ST_SREAD;
                        end else if (chan_ok) begin
                            state_reg <= ST_ISQ;
                        end
                    end
                end
                ST_ISQ: begin
                    if (isq_status.done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_SREAD: begin
                    f_reg     <= rd_factor;
                    bias_reg  <= rd_bias;
                    d_reg     <= diff_val;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= $signed({{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg})
                               + bias_term;
                    state_reg <= ST_MAG;
                end
                ST_MAG: begin
                    neg_reg   <= acc_reg[ACC_W-1];
                    mag_reg   <= acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
                    state_reg <= ST_RND;
                end
                ST_RND: begin
                    rnd_reg   <= load_reg ? (rnd_sum >> 8) : (rnd_sum >> 16);
                    state_reg <= load_reg ? ST_WRITE : ST_OUT;
                end
                ST_WRITE: begin
                    state_reg <= ST_IDLE;
                end
                ST_OUT: begin
                    // wait here while a previous result is still unclaimed
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_value_reg <= y_sat;
                        m_chan_reg  <= chan_reg;
                        m_sat_reg   <= y_clip;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_value = $signed(m_value_reg);
    assign m_out_channel  = m_chan_reg;
    assign m_saturated    = m_sat_reg;

    // ---------------- shared inverse square root unit ----------------
    bnorm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (isq_start),
        .w       (w_val),
        .status  (isq_status),
        .root    (isq_root)
    );

    // ---------------- per-channel factor and offset store ----------------
    bnorm_table u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (ADDR_W'(chan_reg)),
        .wr_data (tbl_wr),
        .rd_en   (tbl_rd_en),
        .rd_addr (ADDR_W'(s_channel)),
        .rd_data (tbl_rd)
    );

    `BNI_ASSERT_IMPLIES(a_ready_isq_idle, aclk, aresetn, s_ready, !isq_status.busy,
        "ready while root unit busy")
    `BNI_ASSERT_NEXT(a_load_starts_isq, aclk, aresetn, isq_start,
        isq_status.busy && (state_reg == ST_ISQ), "load did not start root unit")
    `BNI_ASSERT_NEXT(a_out_stall_holds, aclk, aresetn,
        (state_reg == ST_OUT) && m_valid_reg && !m_ready, state_reg == ST_OUT,
        "result overwritten under stall")

endmodule

[hw/rtl/bnorm_table.sv]
`timescale 1ns / 1ps

module bnorm_table (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [bnorm_pkg::ADDR_W-1:0] wr_addr,
    input  bnorm_pkg::chan_entry_t      wr_data,
    input  logic                        rd_en,
    input  logic [bnorm_pkg::ADDR_W-1:0] rd_addr,
    output bnorm_pkg::chan_entry_t      rd_data
);
    import bnorm_pkg::*;

    chan_entry_t mem [CHANNELS];
    chan_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/bnorm_isqrt.sv]
`timescale 1ns / 1ps
`include "batch_norm_inference_unit_macros.svh"

module bnorm_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bnorm_pkg::W_W-1:0]     w,
    output bnorm_pkg::isqrt_status_t      status,
    output logic [bnorm_pkg::RS_W-1:0]    root
);
    import bnorm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT
    } isq_state_t;

    isq_state_t        state_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [W_W-1:0]    w_reg;
    logic [W_W-1:0]    rem_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [RAD_W-1:0]  x_reg;
    logic [RAD_W-1:0]  res_reg;
    logic [RAD_W-1:0]  one_reg;
    logic [RS_W-1:0]   root_reg;

    // one shared subtractor serves both the divide and the root steps
    logic [RAD_W-1:0]  sub_a;
    logic [RAD_W-1:0]  sub_b;
    logic [RAD_W:0]    diff;
    logic              fits;
    logic [W_W:0]      rem_sh;
    logic [QUO_W-1:0]  quo_next;
    logic [RAD_W-1:0]  res_next;

    always_comb begin
        rem_sh = {rem_reg, (cnt_reg == DIV_TOP)};
        case (state_reg)
            ST_DIV: begin
                sub_a = RAD_W'(rem_sh);
                sub_b = RAD_W'(w_reg);
            end
            ST_SQRT: begin
                sub_a = x_reg;
                sub_b = res_reg | one_reg;
            end
            default: begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
        diff     = {1'b0, sub_a} - {1'b0, sub_b};
        fits     = !diff[RAD_W];
        quo_next = {quo_reg[QUO_W-2:0], fits};
        res_next = fits ? ((res_reg >> 1) | one_reg) : (res_reg >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        w_reg   <= w;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        res_reg <= '0;
                        one_reg <= RAD_W'(1) << (RAD_W - 2);
                        if (w == '0) begin
                            // zero guard: root saturates to all ones
                            x_reg     <= '1;
                            cnt_reg   <= SQRT_TOP;
                            state_reg <= ST_SQRT;
                        end else begin
                            cnt_reg   <= DIV_TOP;
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    rem_reg <= fits ? diff[W_W-1:0] : rem_sh[W_W-1:0];
                    quo_reg <= quo_next;
                    if (cnt_reg == '0) begin
                        x_reg     <= RAD_W'(quo_next);
                        cnt_reg   <= SQRT_TOP;
                        state_reg <= ST_SQRT;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                ST_SQRT: begin
                    if (fits) begin
                        x_reg <= diff[RAD_W-1:0];
                    end
                    res_reg <= res_next;
                    one_reg <= one_reg >> 2;
                    if (cnt_reg == '0) begin
                        root_reg  <= res_next[RS_W-1:0];
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;
    assign root        = root_reg;

    `BNI_ASSERT_IMPLIES(a_isq_start_idle, aclk, aresetn, start, state_reg == ST_IDLE, "isqrt started while busy")
    `BNI_ASSERT_IMPLIES(a_isq_done_idle, aclk, aresetn, done_reg, state_reg == ST_IDLE, "isqrt done outside idle")
    `BNI_ASSERT_IMPLIES(a_isq_one_hot, aclk, aresetn, state_reg == ST_SQRT, $onehot(one_reg), "root trial bit lost")

endmodule

[test/batch_norm_inference_unit_tb.sv]
`timescale 1ns / 1ps

module batch_norm_inference_unit_tb;
    import bnorm_pkg::*;

    // clock, run length and pacing
    localparam int     CLK_HALF       = 10;
    localparam int     RESET_CYCLES   = 12;
    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     LOAD_SETTLE    = 100;   // a load produces no result
    localparam int     RX_HOLD_CYCLES = 600;
    localparam int     SEG_COUNT      = 6;
    localparam int     SEG_ITEMS      = 312;
    localparam longint GAIN_MAX       = 64'sd2147483647;
    localparam longint GAIN_MIN       = -64'sd2147483648;
    localparam longint Y_HI           = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint Y_LO           = -Y_HI - 1;
    localparam logic [PADDR_W-1:0] EPS_ADDR = PADDR_W'(4 * REG_EPSILON);

    // one input transfer, every field a port of its own on the block
    typedef struct {
        logic                          func;
        logic [CHAN_W-1:0]             chan;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [PARAM_W-1:0]     scale;
        logic signed [PARAM_W-1:0]     bias;
        logic signed [PARAM_W-1:0]     mean;
        logic [PARAM_W-1:0]            variance;
    } bn_item_t;

    // one normalized sample as it should leave the block
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] value;
        logic [CHAN_W-1:0]             chan;
        logic                          sat;
    } bn_result_t;

    // directed rows: an item, or an epsilon change made while the block is idle
    typedef enum logic {ROW_ITEM, ROW_EPSILON} row_kind_t;

    typedef struct {
        row_kind_t                     kind;
        bn_item_t                      item;
        bit                            typed;
        logic signed [SAMPLE_BITS-1:0] want_value;
        logic                          want_sat;
        logic [15:0]                   eps;
    } stim_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [PADDR_W-1:0]            paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_func;
    logic [CHAN_W-1:0]             s_channel;
    logic signed [SAMPLE_BITS-1:0] s_sample;
    logic signed [PARAM_W-1:0]     s_scale;
    logic signed [PARAM_W-1:0]     s_bias;
    logic signed [PARAM_W-1:0]     s_mean;
    logic [PARAM_W-1:0]            s_variance;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [SAMPLE_BITS-1:0] m_result_value;
    logic [CHAN_W-1:0]             m_out_channel;
    logic                          m_saturated;

    // shadow of the channel store and the epsilon register
    logic signed [FACT_W-1:0]  gain_tab [CHANNELS];
    logic signed [PARAM_W-1:0] mean_tab [CHANNELS];
    logic signed [PARAM_W-1:0] bias_tab [CHANNELS];
    bit                        chan_loaded [CHANNELS];
    int                        loaded_count;
    logic [15:0]               eps_cfg;

    // normalized samples still owed by the block, oldest first
    bn_result_t norm_pending [$];
    stim_row_t  stim_rows [$];

    int tx_gap_pct;
    int rx_gap_pct;
    bit park_rx;
    int cycle_count;
    int mismatches;
    int results_seen;
    int loads_sent;
    int samples_sent;
    int sat_seen;
    int eps_writes;

    batch_norm_inference_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_channel      (s_channel),
        .s_sample       (s_sample),
        .s_scale        (s_scale),
        .s_bias         (s_bias),
        .s_mean         (s_mean),
        .s_variance     (s_variance),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_out_channel  (m_out_channel),
        .m_saturated    (m_saturated)
    );

    initial aclk = 1'b0;

    always begin
        #CLK_HALF aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("batch_norm_inference_unit regression: fail");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // magnitude rounding, half away from zero
    function automatic longint round_away(input longint v, input int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return (v < 0) ? -mag : mag;
    endfunction

    // floor(1/sqrt(w)) in q9.16, built bit by bit from the top
    function automatic logic [RS_W-1:0] recip_root(input logic [W_W-1:0] w);
        longint unsigned limit;
        longint unsigned cand;
        logic [RS_W-1:0] r;
        limit = (w == '0) ? 64'hFFFF_FFFF_FFFF_FFFF : (64'd1 << 48) / w;
        r = '0;
        for (int b = RS_W - 1; b >= 0; b--) begin
            cand = longint'(r) | (64'd1 << b);
            if (cand * cand <= limit) begin
                r = RS_W'(cand);
            end
        end
        return r;
    endfunction

    // parameter load: factor = scale / sqrt(variance + epsilon), kept as q16.16
    function automatic void load_channel(input bn_item_t it);
        logic [W_W-1:0] w;
        longint         fac;
        w = {1'b0, it.variance, 8'h00} + W_W'(eps_cfg);
        fac = round_away(longint'(it.scale) * longint'(recip_root(w)), 8);
        if (fac > GAIN_MAX) fac = GAIN_MAX;
        if (fac < GAIN_MIN) fac = GAIN_MIN;
        gain_tab[it.chan] = FACT_W'(fac);
        mean_tab[it.chan] = it.mean;
        bias_tab[it.chan] = it.bias;
        if (!chan_loaded[it.chan]) begin
            chan_loaded[it.chan] = 1'b1;
            loaded_count++;
        end
    endfunction

    // sample: factor * (x - mean) + bias, rounded back to q8.8 and clipped
    function automatic bn_result_t normalize(input bn_item_t it);
        bn_result_t r;
        longint     acc;
        longint     y;
        acc = longint'(gain_tab[it.chan])
              * (longint'(it.sample) - longint'(mean_tab[it.chan]))
              + longint'(bias_tab[it.chan]) * 65536;
        y = round_away(acc, 16);
        r.sat = 1'b0;
        if (y > Y_HI) begin
            y = Y_HI;
            r.sat = 1'b1;
        end
        if (y < Y_LO) begin
            y = Y_LO;
            r.sat = 1'b1;
        end
        r.value = SAMPLE_BITS'(y);
        r.chan = it.chan;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // mostly values within +-span, some full random words, some corner words
    function automatic logic [15:0] pick_word(input int span);
        int r;
        r = $urandom_range(99);
        if (r < 12) begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                3: return 16'hFFFF;
                default: return 16'h0001;
            endcase
        end
        if (r < 30) return 16'($urandom);
        return 16'($urandom_range(2 * span) - span);
    endfunction

    function automatic logic [15:0] pick_variance();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 16'($urandom_range(3));
        if (r < 22) return 16'($urandom);
        if (r < 26) return 16'hFFFF;
        return 16'($urandom_range(4096, 8));
    endfunction

    // loads on random channels, samples only on channels already loaded
    function automatic bn_item_t rand_item();
        bn_item_t it;
        it.sample   = 16'($urandom);
        it.scale    = 16'($urandom);
        it.bias     = 16'($urandom);
        it.mean     = 16'($urandom);
        it.variance = 16'($urandom);
        if (loaded_count == 0 || $urandom_range(99) < 28) begin
            it.func     = FUNC_LOAD;
            it.chan     = CHAN_W'($urandom_range(CHANNELS - 1));
            it.scale    = pick_word(1024);
            it.bias     = pick_word(2048);
            it.mean     = pick_word(2048);
            it.variance = pick_variance();
        end else begin
            it.func = FUNC_SAMPLE;
            do begin
                it.chan = CHAN_W'($urandom_range(CHANNELS - 1));
            end while (!chan_loaded[it.chan]);
            // most samples sit near the channel mean so the output is not pinned
            if ($urandom_range(99) < 60) begin
                it.sample = mean_tab[it.chan] + pick_word(1024);
            end else begin
                it.sample = pick_word(4096);
            end
        end
        return it;
    endfunction

    // ---------------------------------------------------------------- driving

    // random sender gaps after a transfer; valid drops only if a gap is taken
    task automatic tx_idle();
        bit lowered;
        lowered = 1'b0;
        while ($urandom_range(99) < tx_gap_pct) begin
            if (!lowered) begin
                s_valid <= 1'b0;
                lowered = 1'b1;
            end
            @(posedge aclk);
        end
    endtask

    // offer one item, hold it until the transfer, then book what it should cause
    task automatic send_item(input bn_item_t it, input bit typed,
                             input logic signed [SAMPLE_BITS-1:0] want_value,
                             input logic want_sat);
        bn_result_t r;
        s_valid    <= 1'b1;
        s_func     <= it.func;
        s_channel  <= it.chan;
        s_sample   <= it.sample;
        s_scale    <= it.scale;
        s_bias     <= it.bias;
        s_mean     <= it.mean;
        s_variance <= it.variance;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        if (it.func == FUNC_LOAD) begin
            load_channel(it);
            loads_sent++;
        end else begin
            r = normalize(it);
            // rows with a hand-written answer take it instead of the predictor's
            if (typed) begin
                r.value = want_value;
                r.sat   = want_sat;
            end
            norm_pending.push_back(r);
            samples_sent++;
        end
        tx_idle();
    endtask

    // sender stands still until every owed result has come out
    task automatic drain_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (norm_pending.size() != 0);
    endtask

    // one apb transfer: setup cycle, then access cycle; read data taken mid-access
    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        rdata = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_epsilon(input logic [15:0] want);
        logic [31:0] rd;
        apb_xfer(1'b0, EPS_ADDR, 32'h0, rd);
        if (rd[15:0] !== want) begin
            $error("epsilon readback mismatch: expected %0d, actual %0d", want, rd[15:0]);
            mismatches++;
        end
    endtask

    // epsilon only changes with the block idle: drained, plus a load's worth of cycles
    task automatic write_epsilon(input logic [15:0] v);
        logic [31:0] rd;
        drain_results();
        repeat (LOAD_SETTLE) @(posedge aclk);
        apb_xfer(1'b1, EPS_ADDR, {16'h0, v}, rd);
        eps_cfg = v;
        eps_writes++;
        @(posedge aclk);
        check_epsilon(v);
    endtask

    function automatic void add_load(input int ch, input logic [15:0] scale,
                                     input logic [15:0] bias, input logic [15:0] mean,
                                     input logic [15:0] variance);
        stim_row_t row;
        row.kind          = ROW_ITEM;
        row.item.func     = FUNC_LOAD;
        row.item.chan     = CHAN_W'(ch);
        row.item.sample   = '0;
        row.item.scale    = scale;
        row.item.bias     = bias;
        row.item.mean     = mean;
        row.item.variance = variance;
        row.typed         = 1'b0;
        row.want_value    = '0;
        row.want_sat      = 1'b0;
        row.eps           = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_sample(input int ch, input logic [15:0] x, input bit typed,
                                       input logic [15:0] want_value, input logic want_sat);
        stim_row_t row;
        row.kind          = ROW_ITEM;
        row.item.func     = FUNC_SAMPLE;
        row.item.chan     = CHAN_W'(ch);
        row.item.sample   = x;
        row.item.scale    = '0;
        row.item.bias     = '0;
        row.item.mean     = '0;
        row.item.variance = '0;
        row.typed         = typed;
        row.want_value    = want_value;
        row.want_sat      = want_sat;
        row.eps           = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_epsilon(input logic [15:0] v);
        stim_row_t row;
        row.kind       = ROW_EPSILON;
        row.item       = rand_item();
        row.typed      = 1'b0;
        row.want_value = '0;
        row.want_sat   = 1'b0;
        row.eps        = v;
        stim_rows.push_back(row);
    endfunction

    // ---------------------------------------------------------------- result side

    task automatic check_norm_output();
        bn_result_t want;
        if (norm_pending.size() == 0) begin
            $error("result transfer with nothing owed: channel %0d value %0d",
                   m_out_channel, m_result_value);
            mismatches++;
            return;
        end
        want = norm_pending.pop_front();
        results_seen++;
        if (m_saturated === 1'b1) sat_seen++;
        if (m_result_value !== want.value) begin
            $error("result_value mismatch: expected %0d, actual %0d",
                   want.value, m_result_value);
            mismatches++;
        end
        if (m_out_channel !== want.chan) begin
            $error("out_channel mismatch: expected %0d, actual %0d",
                   want.chan, m_out_channel);
            mismatches++;
        end
        if (m_saturated !== want.sat) begin
            $error("saturated mismatch: expected %0d, actual %0d",
                   want.sat, m_saturated);
            mismatches++;
        end
    endtask

    // receiver: random ready, plus a long hold-off on request, counted here
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
                check_norm_output();
            end
            if (park_rx) begin
                park_rx = 1'b0;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_gap_pct);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin : tx_side
        logic [15:0] seg_eps;
        bn_item_t    it;

        mismatches   = 0;
        results_seen = 0;
        loads_sent   = 0;
        samples_sent = 0;
        sat_seen     = 0;
        eps_writes   = 0;
        loaded_count = 0;
        park_rx      = 1'b0;
        tx_gap_pct   = 6;
        rx_gap_pct   = 71;
        eps_cfg      = EPS_RESET;
        foreach (chan_loaded[i]) chan_loaded[i] = 1'b0;

        aresetn    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        s_valid    <= 1'b0;
        s_func     <= FUNC_LOAD;
        s_channel  <= '0;
        s_sample   <= '0;
        s_scale    <= '0;
        s_bias     <= '0;
        s_mean     <= '0;
        s_variance <= '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // epsilon comes out of reset at one
        check_epsilon(EPS_RESET);

        // directed part, epsilon at its reset value first
        // zero scale: every sample collapses onto the bias
        add_load(0, 16'h0000, 16'h1234, 16'h0100, 16'h0100);
        add_sample(0, 16'h7FFF, 1, 16'h1234, 1'b0);
        add_sample(0, 16'h8000, 1, 16'h1234, 1'b0);
        // largest positive gain, widest spread: clips high
        add_load(63, 16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
        add_sample(63, 16'h7FFF, 1, 16'h7FFF, 1'b1);
        // most negative gain lands exactly on the q16.16 floor
        add_load(63, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        add_sample(63, 16'h0001, 0, '0, 1'b0);
        add_sample(63, 16'h7FFF, 1, 16'h8000, 1'b1);
        // largest variance, unit scale
        add_load(1, 16'h0100, 16'h0000, 16'h0000, 16'hFFFF);
        add_sample(1, 16'h7FFF, 0, '0, 1'b0);
        add_sample(1, 16'h0000, 1, 16'h0000, 1'b0);
        // sample equal to the mean gives the bias, here the most negative one
        add_load(2, 16'hFF00, 16'h8000, 16'h7FFF, 16'h0100);
        add_sample(2, 16'h7FFF, 1, 16'h8000, 1'b0);
        add_sample(2, 16'h8000, 0, '0, 1'b0);
        // reload of a channel replaces all of its entry
        add_load(2, 16'h7FFF, 16'h7FFF, 16'h0000, 16'hFFFF);
        add_sample(2, 16'h0000, 1, 16'h7FFF, 1'b0);
        add_sample(2, 16'h4000, 0, '0, 1'b0);
        // zero guard: no variance and no epsilon gives an all-ones root
        add_epsilon(16'h0000);
        add_load(5, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        add_sample(5, 16'h0100, 0, '0, 1'b0);
        // same root with a large scale clips the stored factor
        add_load(6, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
        add_sample(6, 16'h0001, 0, '0, 1'b0);
        add_sample(6, 16'hFFFF, 0, '0, 1'b0);
        // largest epsilon
        add_epsilon(16'hFFFF);
        add_load(7, 16'h4000, 16'hFF00, 16'h0080, 16'h0000);
        add_sample(7, 16'h0080, 1, 16'hFF00, 1'b0);
        add_sample(7, 16'h1234, 0, '0, 1'b0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_EPSILON) begin
                write_epsilon(stim_rows[i].eps);
            end else begin
                send_item(stim_rows[i].item, stim_rows[i].typed,
                          stim_rows[i].want_value, stim_rows[i].want_sat);
            end
        end

        // random part: each segment its own epsilon; segments share an idling mix in pairs
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg)
                0: seg_eps = 16'h0000;
                1: seg_eps = 16'hFFFF;
                3: seg_eps = EPS_RESET;
                default: seg_eps = 16'($urandom);
            endcase
            write_epsilon(seg_eps);
            if (seg < 2) begin
                tx_gap_pct = 6;
                rx_gap_pct = 71;
            end else if (seg < 4) begin
                tx_gap_pct = 71;
                rx_gap_pct = 6;
            end else begin
                tx_gap_pct = 0;
                rx_gap_pct = 0;
            end
            for (int n = 0; n < SEG_ITEMS; n++) begin
                // long receiver hold-off while items keep coming: block backs up
                if (seg == 0 && n == 40) park_rx = 1'b1;
                // one pause on the sending side until everything owed is out
                if (seg == 2 && n == 150) drain_results();
                it = rand_item();
                send_item(it, 1'b0, '0, 1'b0);
            end
        end

        drain_results();
        repeat (LOAD_SETTLE) @(posedge aclk);

        $display("covered %0d loads and %0d samples over %0d epsilon writes, zero guard included",
                 loads_sent, samples_sent, eps_writes);
        $display("%0d results checked, %0d clipped, %0d mismatches",
                 results_seen, sat_seen, mismatches);
        if (mismatches == 0) begin
            $display("batch_norm_inference_unit regression: pass");
        end else begin
            $display("batch_norm_inference_unit regression: fail");
        end
        $finish;
    end

endmodule
